// ===== rtl/complex_poly_matrix_convolution_core_macros.svh =====
// Assertion macros shared by the polynomial matrix convolution core.
// Needs clk and rst in the scope of each use; NO_ASSERTIONS empties them.
`ifndef COMPLEX_POLY_MATRIX_CONVOLUTION_CORE_MACROS_SVH
`define COMPLEX_POLY_MATRIX_CONVOLUTION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CPMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPMC_ASSERT_IMPL(lbl, ante, cons, msg)
`define CPMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cpmc_pkg.sv =====
// Shared types and constants of the polynomial matrix convolution core.
// No dependencies; used by the controller, the datapath and the top level.
package cpmc_pkg;

  localparam int TAP_W      = 5;   // tap field
  localparam int IDX_W      = 3;   // row and column fields
  localparam int K_W        = 4;   // inner index, bounded by the 4-bit size register
  localparam int IN_ELEM_W  = 16;  // element width on the stream
  localparam int ACC_W      = 40;
  localparam int LEAD_W     = 10;
  localparam int LEAD_SUM_W = 11;
  localparam int DIM_REG_W  = 4;
  localparam int TAP_REG_W  = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int S_TDATA_W  = 48;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 96;
  localparam int M_TUSER_W  = 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_READ   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 3'd0,
    REG_INNER_DIM = 3'd1,
    REG_COLS_B    = 3'd2,
    REG_TAPS_A    = 3'd3,
    REG_TAPS_B    = 3'd4,
    REG_LEAD_A    = 3'd5,
    REG_LEAD_B    = 3'd6
  } cfg_reg_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic             capture;   // take the element of the accepted word
    logic             wr_a;
    logic             wr_b;
    logic             rd_issue;  // read one A/B element pair
    logic [TAP_W-1:0] tap_a;
    logic [TAP_W-1:0] tap_b;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [K_W-1:0]   k;
    logic             acc_clear;
    logic             load_out;
    logic             use_acc;
    logic             status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic pipe_busy;
  } stat_t;

endpackage

// ===== rtl/complex_poly_matrix_convolution_core.sv =====
// Top level of the complex polynomial matrix convolution core.
// Depends on cpmc_pkg, cpmc_ctrl, cpmc_dp (and through it cpmc_ram).
//
// Use: configure sizes and lead indices on the cfg port (cfg_wen, cfg_index,
// cfg_data) while the core is idle, then stream words on the s_ side. A word
// either loads one complex element of A or B (tap, row, col) or asks for one
// coefficient of the product. Every word gives exactly one result word on the
// m_ side: the coefficient (zero for loads and rejected words), the sum of
// the lead indices and a status flag set for an address outside the
// configured sizes or for an undefined action. A load or a rejected word
// passes from idle through the check and finish states into the output
// register. A read walks N = (tap pairs in use) x inner_dim element pairs
// in turn through one complex multiply-accumulate unit (the two saturating
// steps of each sum share one accumulator) and drains it before output.
// One word is worked on at a time; s_tready is high while the core is idle.
// Reset clears the control state, sets all sizes to 1 and the lead indices to
// 0; the element stores are not cleared and must be written before read.
// If m_tready is held low the result waits in the output register; the core
// still takes the next word and stalls only when that one's result is ready.
module complex_poly_matrix_convolution_core #(
  parameter int MAX_DIM   = 8,
  parameter int MAX_TAPS  = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tap[4:0], row[7:5], col[10:8], elem_re[26:11], elem_im[42:27], zero [47:43]
  input  logic [cpmc_pkg::S_TDATA_W-1:0]      s_tdata,
  // action[1:0]
  input  logic [cpmc_pkg::S_TUSER_W-1:0]      s_tuser,
  // result words
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // prod_re[39:0], prod_im[79:40], lead_index_out[90:80], zero [95:91]
  output logic [cpmc_pkg::M_TDATA_W-1:0]      m_tdata,
  // status[0]
  output logic [cpmc_pkg::M_TUSER_W-1:0]      m_tuser,
  // configuration writes
  input  logic                                cfg_wen,
  input  logic [cpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cpmc_pkg::cmd_t  cmd;
  cpmc_pkg::stat_t stat;

  logic signed [cpmc_pkg::ACC_W-1:0] prod_re, prod_im;
  logic [cpmc_pkg::LEAD_SUM_W-1:0]   lead_index_out;
  logic                              status;

  cpmc_ctrl #(
    .MAX_DIM  (MAX_DIM),
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .action    (s_tuser[1:0]),
    .tap       (s_tdata[4:0]),
    .row       (s_tdata[7:5]),
    .col       (s_tdata[10:8]),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpmc_dp #(
    .MAX_DIM   (MAX_DIM),
    .MAX_TAPS  (MAX_TAPS),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .elem_re        (s_tdata[26:11]),
    .elem_im        (s_tdata[42:27]),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .prod_re        (prod_re),
    .prod_im        (prod_im),
    .lead_index_out (lead_index_out),
    .status         (status)
  );

  assign m_tdata = {5'b0, lead_index_out, prod_im, prod_re};
  assign m_tuser = status;

endmodule

// ===== rtl/cpmc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module cpmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic                    re,
  input  logic [ADDR_W-1:0]       addr,
  input  logic [WIDTH-1:0]        wdata,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/cpmc_ctrl.sv =====
// Controller of the polynomial matrix convolution core: size registers,
// range checks and the tap/inner-index walk. Uses cpmc_pkg and the macro header.
`include "complex_poly_matrix_convolution_core_macros.svh"

module cpmc_ctrl #(
  parameter int MAX_DIM  = 8,
  parameter int MAX_TAPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [1:0]                          action,
  input  logic [cpmc_pkg::TAP_W-1:0]          tap,
  input  logic [cpmc_pkg::IDX_W-1:0]          row,
  input  logic [cpmc_pkg::IDX_W-1:0]          col,
  input  logic                                cfg_wen,
  input  logic [cpmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpmc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  cpmc_pkg::stat_t                     stat,
  output cpmc_pkg::cmd_t                      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [cpmc_pkg::DIM_REG_W-1:0] rows_a, inner_dim, cols_b;
  logic [cpmc_pkg::TAP_REG_W-1:0] taps_a, taps_b;
  logic [cpmc_pkg::DIM_REG_W-1:0] nr, nk, nc;
  logic [cpmc_pkg::TAP_REG_W-1:0] ta, tb;

  logic [1:0]                 act_r;
  logic [cpmc_pkg::TAP_W-1:0] tap_r;
  logic [cpmc_pkg::IDX_W-1:0] row_r, col_r;
  logic [cpmc_pkg::TAP_W-1:0] i_cnt, i_end;
  logic [cpmc_pkg::K_W-1:0]   k_cnt;
  logic                       phase;
  logic                       status_r, use_acc_r;

  logic                       ok_a, ok_b, ok_rd, item_ok;
  logic [cpmc_pkg::TAP_W-1:0] i_start, i_last;
  logic                       last_pair;

  function automatic logic [cpmc_pkg::DIM_REG_W-1:0] clamp_dim(
    input logic [cpmc_pkg::DIM_REG_W-1:0] v
  );
    if (v == '0) return cpmc_pkg::DIM_REG_W'(1);
    if (32'(v) > MAX_DIM) return cpmc_pkg::DIM_REG_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [cpmc_pkg::TAP_REG_W-1:0] clamp_taps(
    input logic [cpmc_pkg::TAP_REG_W-1:0] v
  );
    if (v == '0) return cpmc_pkg::TAP_REG_W'(1);
    if (32'(v) > MAX_TAPS) return cpmc_pkg::TAP_REG_W'(MAX_TAPS);
    return v;
  endfunction

  assign nr = clamp_dim(rows_a);
  assign nk = clamp_dim(inner_dim);
  assign nc = clamp_dim(cols_b);
  assign ta = clamp_taps(taps_a);
  assign tb = clamp_taps(taps_b);

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= cpmc_pkg::DIM_REG_W'(1);
      inner_dim <= cpmc_pkg::DIM_REG_W'(1);
      cols_b    <= cpmc_pkg::DIM_REG_W'(1);
      taps_a    <= cpmc_pkg::TAP_REG_W'(1);
      taps_b    <= cpmc_pkg::TAP_REG_W'(1);
    end else if (cfg_wen) begin
      case (cpmc_pkg::cfg_reg_t'(cfg_index))
        cpmc_pkg::REG_ROWS_A:    rows_a    <= cfg_data[cpmc_pkg::DIM_REG_W-1:0];
        cpmc_pkg::REG_INNER_DIM: inner_dim <= cfg_data[cpmc_pkg::DIM_REG_W-1:0];
        cpmc_pkg::REG_COLS_B:    cols_b    <= cfg_data[cpmc_pkg::DIM_REG_W-1:0];
        cpmc_pkg::REG_TAPS_A:    taps_a    <= cfg_data[cpmc_pkg::TAP_REG_W-1:0];
        cpmc_pkg::REG_TAPS_B:    taps_b    <= cfg_data[cpmc_pkg::TAP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // range checks on the held address
  always_comb begin
    ok_a  = (tap_r < ta) && ({1'b0, row_r} < nr) && ({1'b0, col_r} < nk);
    ok_b  = (tap_r < tb) && ({1'b0, row_r} < nk) && ({1'b0, col_r} < nc);
    ok_rd = ({1'b0, tap_r} < ({1'b0, ta} + {1'b0, tb} - 6'd1))
            && ({1'b0, row_r} < nr) && ({1'b0, col_r} < nc);
    case (act_r)
      cpmc_pkg::ACT_LOAD_A: item_ok = ok_a;
      cpmc_pkg::ACT_LOAD_B: item_ok = ok_b;
      cpmc_pkg::ACT_READ:   item_ok = ok_rd;
      default:              item_ok = 1'b0;
    endcase
    // first A tap whose partner B tap lies below taps_b, last A tap in use
    i_start   = (tap_r >= tb) ? (tap_r - tb + cpmc_pkg::TAP_W'(1)) : '0;
    i_last    = ((ta - cpmc_pkg::TAP_W'(1)) < tap_r) ? (ta - cpmc_pkg::TAP_W'(1)) : tap_r;
    last_pair = (k_cnt == (nk - cpmc_pkg::K_W'(1))) && (i_cnt == i_end);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK:  state_next = (item_ok && (act_r == cpmc_pkg::ACT_READ)) ? ST_WALK : ST_FINISH;
      ST_WALK:   if (!phase && last_pair) state_next = ST_DRAIN;
      ST_DRAIN:  if (!stat.pipe_busy) state_next = ST_FINISH;
      ST_FINISH: if (stat.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      status_r  <= cpmc_pkg::STATUS_OK;
      use_acc_r <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            act_r <= action;
            tap_r <= tap;
            row_r <= row;
            col_r <= col;
          end
        end
        ST_CHECK: begin
          status_r  <= item_ok ? cpmc_pkg::STATUS_OK : cpmc_pkg::STATUS_ERR;
          use_acc_r <= item_ok && (act_r == cpmc_pkg::ACT_READ);
          i_cnt     <= i_start;
          i_end     <= i_last;
          k_cnt     <= '0;
          phase     <= 1'b0;
        end
        ST_WALK: begin
          phase <= ~phase;
          if (!phase) begin
            if (k_cnt == (nk - cpmc_pkg::K_W'(1))) begin
              k_cnt <= '0;
              i_cnt <= i_cnt + cpmc_pkg::TAP_W'(1);
            end else begin
              k_cnt <= k_cnt + cpmc_pkg::K_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // no word is taken while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd           = '0;
    cmd.capture   = s_tvalid && s_tready;
    cmd.wr_a      = (state == ST_CHECK) && ok_a && (act_r == cpmc_pkg::ACT_LOAD_A);
    cmd.wr_b      = (state == ST_CHECK) && ok_b && (act_r == cpmc_pkg::ACT_LOAD_B);
    cmd.rd_issue  = (state == ST_WALK) && !phase;
    cmd.tap_a     = (state == ST_WALK) ? i_cnt : tap_r;
    cmd.tap_b     = (state == ST_WALK) ? (tap_r - i_cnt) : tap_r;
    cmd.row       = row_r;
    cmd.col       = col_r;
    cmd.k         = k_cnt;
    cmd.acc_clear = (state == ST_CHECK);
    cmd.load_out  = (state == ST_FINISH) && stat.out_free;
    cmd.use_acc   = use_acc_r;
    cmd.status    = status_r;
  end

  `CPMC_ASSERT_NEXT(a_accept_goes_check, s_tvalid && s_tready, state == ST_CHECK, "accepted word did not reach the check state")
  `CPMC_ASSERT_IMPL(a_walk_k_in_range, state == ST_WALK, k_cnt < nk, "inner index ran past inner_dim")
  `CPMC_ASSERT_IMPL(a_issue_taps_valid, cmd.rd_issue, (i_cnt <= i_end) && (cmd.tap_b < tb), "read issued for a tap pair outside the sizes")

endmodule

// ===== rtl/cpmc_dp.sv =====
// Datapath of the polynomial matrix convolution core: element stores,
// complex multiply-accumulate and the output register. Uses cpmc_pkg, cpmc_ram
// and the macro header.
`include "complex_poly_matrix_convolution_core_macros.svh"

module cpmc_dp #(
  parameter int MAX_DIM   = 8,
  parameter int MAX_TAPS  = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cpmc_pkg::cmd_t                        cmd,
  output cpmc_pkg::stat_t                       stat,
  input  logic [cpmc_pkg::IN_ELEM_W-1:0]        elem_re,
  input  logic [cpmc_pkg::IN_ELEM_W-1:0]        elem_im,
  input  logic                                  cfg_wen,
  input  logic [cpmc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpmc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic signed [cpmc_pkg::ACC_W-1:0]     prod_re,
  output logic signed [cpmc_pkg::ACC_W-1:0]     prod_im,
  output logic [cpmc_pkg::LEAD_SUM_W-1:0]       lead_index_out,
  output logic                                  status
);

  localparam int DEPTH   = MAX_TAPS * MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDE_W  = ADDR_W + 16;
  localparam int IN_BITS = (ELEM_BITS < cpmc_pkg::IN_ELEM_W) ? ELEM_BITS : cpmc_pkg::IN_ELEM_W;
  localparam int PW      = 2 * ELEM_BITS;
  localparam int SUM_W   = (PW + 2 > cpmc_pkg::ACC_W + 1) ? PW + 2 : cpmc_pkg::ACC_W + 1;

  logic signed [ELEM_BITS-1:0] er, ei;
  logic [2*ELEM_BITS-1:0]      a_q, b_q;
  logic [ADDR_W-1:0]           a_addr, b_addr;
  logic signed [ELEM_BITS-1:0] ar, ai, br, bi;
  logic signed [ELEM_BITS-1:0] mul_a, mul_b0, mul_b1;
  logic signed [PW-1:0]        p0, p1;
  logic                        v1, v2, v3;
  logic signed [cpmc_pkg::ACC_W-1:0] acc_re, acc_im;
  logic signed [SUM_W-1:0]     re_term, re_sum, im_sum;
  logic [cpmc_pkg::LEAD_W-1:0] lead_a, lead_b;

  function automatic logic [ADDR_W-1:0] elem_addr(
    input logic [cpmc_pkg::TAP_W-1:0] t,
    input logic [cpmc_pkg::K_W-1:0]   r,
    input logic [cpmc_pkg::K_W-1:0]   c
  );
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(t) * WIDE_W'(MAX_DIM * MAX_DIM) + WIDE_W'(r) * WIDE_W'(MAX_DIM) + WIDE_W'(c);
    return w[ADDR_W-1:0];
  endfunction

  function automatic logic signed [cpmc_pkg::ACC_W-1:0] sat_acc(
    input logic signed [SUM_W-1:0] s
  );
    if (s > SUM_W'(cpmc_pkg::ACC_MAX)) return cpmc_pkg::ACC_MAX;
    if (s < SUM_W'(cpmc_pkg::ACC_MIN)) return cpmc_pkg::ACC_MIN;
    return cpmc_pkg::ACC_W'(s);
  endfunction

  // element of the accepted word, sign extended from its low IN_BITS
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      er <= ELEM_BITS'($signed(elem_re[IN_BITS-1:0]));
      ei <= ELEM_BITS'($signed(elem_im[IN_BITS-1:0]));
    end
  end

  always_comb begin
    if (cmd.rd_issue) begin
      a_addr = elem_addr(cmd.tap_a, cpmc_pkg::K_W'(cmd.row), cmd.k);
      b_addr = elem_addr(cmd.tap_b, cmd.k, cpmc_pkg::K_W'(cmd.col));
    end else begin
      a_addr = elem_addr(cmd.tap_a, cpmc_pkg::K_W'(cmd.row), cpmc_pkg::K_W'(cmd.col));
      b_addr = elem_addr(cmd.tap_b, cpmc_pkg::K_W'(cmd.row), cpmc_pkg::K_W'(cmd.col));
    end
  end

  // real part low, imaginary part high
  cpmc_ram #(.WIDTH(2 * ELEM_BITS), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a),
    .re    (cmd.rd_issue),
    .addr  (a_addr),
    .wdata ({ei, er}),
    .rdata (a_q)
  );

  cpmc_ram #(.WIDTH(2 * ELEM_BITS), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b),
    .re    (cmd.rd_issue),
    .addr  (b_addr),
    .wdata ({ei, er}),
    .rdata (b_q)
  );

  assign ar = $signed(a_q[ELEM_BITS-1:0]);
  assign ai = $signed(a_q[2*ELEM_BITS-1:ELEM_BITS]);
  assign br = $signed(b_q[ELEM_BITS-1:0]);
  assign bi = $signed(b_q[2*ELEM_BITS-1:ELEM_BITS]);

  // v1: Ar*Br and Ar*Bi; v2: Ai*Bi and Ai*Br
  assign mul_a  = v1 ? ar : ai;
  assign mul_b0 = v1 ? br : bi;
  assign mul_b1 = v1 ? bi : br;

  always_ff @(posedge clk) begin
    if (v1 || v2) begin
      p0 <= PW'(mul_a) * PW'(mul_b0);
      p1 <= PW'(mul_a) * PW'(mul_b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.rd_issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    re_term = v3 ? -SUM_W'(p0) : SUM_W'(p0);
    re_sum  = SUM_W'(acc_re) + re_term;
    im_sum  = SUM_W'(acc_im) + SUM_W'(p1);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2 || v3) begin
      acc_re <= sat_acc(re_sum);
      acc_im <= sat_acc(im_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_a <= '0;
      lead_b <= '0;
    end else if (cfg_wen) begin
      case (cpmc_pkg::cfg_reg_t'(cfg_index))
        cpmc_pkg::REG_LEAD_A: lead_a <= cfg_data[cpmc_pkg::LEAD_W-1:0];
        cpmc_pkg::REG_LEAD_B: lead_b <= cfg_data[cpmc_pkg::LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      prod_re        <= cmd.use_acc ? acc_re : '0;
      prod_im        <= cmd.use_acc ? acc_im : '0;
      lead_index_out <= cpmc_pkg::LEAD_SUM_W'(lead_a) + cpmc_pkg::LEAD_SUM_W'(lead_b);
      status         <= cmd.status;
    end
  end

  assign stat = '{out_free: !m_tvalid || m_tready, pipe_busy: v1 || v2 || v3};

  `CPMC_ASSERT_IMPL(a_load_needs_room, cmd.load_out, !m_tvalid || m_tready, "output overwritten while stalled")
  `CPMC_ASSERT_IMPL(a_clear_when_quiet, cmd.acc_clear, !(v1 || v2 || v3), "accumulator cleared with products in flight")
  `CPMC_ASSERT_NEXT(a_issue_spacing, cmd.rd_issue, !cmd.rd_issue, "element pairs issued closer than two cycles")

endmodule

// ===== sim/complex_poly_matrix_convolution_core_test.sv =====
// Testbench for complex_poly_matrix_convolution_core: streams load and read words,
// predicts every result word in the bench and checks it field by field.
// Depends on cpmc_pkg and the core itself.
module complex_poly_matrix_convolution_core_test;
  import cpmc_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int MAX_TAPS = 16;
  localparam int STALL_LIMIT = 2000;   // cycles with no word moving on either side
  localparam int MAX_SHOWN = 10;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [1:0] ACT_NONE = 2'd3;   // undefined action, answers with an error
  localparam longint ACC_HI = longint'(ACC_MAX);
  localparam longint ACC_LO = longint'(ACC_MIN);

  // one result word as the core should give it
  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic [LEAD_SUM_W-1:0]   lead;
    logic                    status;
  } coef_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // bench copy of the register file, raw values as written
  logic [DIM_REG_W-1:0] rows_a_reg = 4'd1;
  logic [DIM_REG_W-1:0] inner_reg = 4'd1;
  logic [DIM_REG_W-1:0] cols_b_reg = 4'd1;
  logic [TAP_REG_W-1:0] taps_a_reg = 5'd1;
  logic [TAP_REG_W-1:0] taps_b_reg = 5'd1;
  logic [LEAD_W-1:0]    lead_a_reg = '0;
  logic [LEAD_W-1:0]    lead_b_reg = '0;

  // bench copy of the element stores, slot = (tap*MAX_DIM + row)*MAX_DIM + col
  logic signed [IN_ELEM_W-1:0] a_re_mem [MAX_TAPS*MAX_DIM*MAX_DIM];
  logic signed [IN_ELEM_W-1:0] a_im_mem [MAX_TAPS*MAX_DIM*MAX_DIM];
  logic signed [IN_ELEM_W-1:0] b_re_mem [MAX_TAPS*MAX_DIM*MAX_DIM];
  logic signed [IN_ELEM_W-1:0] b_im_mem [MAX_TAPS*MAX_DIM*MAX_DIM];

  coef_t expected_coefs [$];
  int    bad_words = 0;
  int    quiet_cycles = 0;
  int    idle_pct = 20;     // chance of an idle burst, both sides
  logic  calm = 1'b0;       // no idling at all near the end

  complex_poly_matrix_convolution_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  // size registers: 0 behaves as 1, anything past the limit as the limit
  function automatic int unsigned eff_size(input int unsigned raw, input int unsigned lim);
    if (raw == 0) return 1;
    return (raw > lim) ? lim : raw;
  endfunction

  function automatic longint sat_acc(input longint acc, input longint term);
    longint s;
    s = acc + term;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Applies one word to the bench stores and works out its result word.
  function automatic coef_t predict_coef(input logic [1:0] act, input logic [TAP_W-1:0] tap,
                                         input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                         input logic signed [IN_ELEM_W-1:0] el_re,
                                         input logic signed [IN_ELEM_W-1:0] el_im);
    int unsigned nr, nk, nc, ta, tb;
    int     t, r, c, sa, sb;
    longint acc_re, acc_im, ar, ai, br, bi;
    coef_t  res;
    nr = eff_size(rows_a_reg, MAX_DIM);
    nk = eff_size(inner_reg, MAX_DIM);
    nc = eff_size(cols_b_reg, MAX_DIM);
    ta = eff_size(taps_a_reg, MAX_TAPS);
    tb = eff_size(taps_b_reg, MAX_TAPS);
    t = tap;
    r = row;
    c = col;
    acc_re = 0;
    acc_im = 0;
    res.status = STATUS_OK;
    case (act)
      ACT_LOAD_A: begin
        if (t < ta && r < nr && c < nk) begin
          sa = (t * MAX_DIM + r) * MAX_DIM + c;
          a_re_mem[sa] = el_re;
          a_im_mem[sa] = el_im;
        end else begin
          res.status = STATUS_ERR;
        end
      end
      ACT_LOAD_B: begin
        if (t < tb && r < nk && c < nc) begin
          sb = (t * MAX_DIM + r) * MAX_DIM + c;
          b_re_mem[sb] = el_re;
          b_im_mem[sb] = el_im;
        end else begin
          res.status = STATUS_ERR;
        end
      end
      ACT_READ: begin
        if (t < ta + tb - 1 && r < nr && c < nc) begin
          // tap t of the product: every A tap i paired with B tap t-i
          for (int i = 0; i < ta; i++) begin
            if (i <= t && t - i < tb) begin
              for (int k = 0; k < nk; k++) begin
                sa = (i * MAX_DIM + r) * MAX_DIM + k;
                sb = ((t - i) * MAX_DIM + k) * MAX_DIM + c;
                ar = a_re_mem[sa];
                ai = a_im_mem[sa];
                br = b_re_mem[sb];
                bi = b_im_mem[sb];
                acc_re = sat_acc(acc_re, ar * br);
                acc_re = sat_acc(acc_re, -(ai * bi));
                acc_im = sat_acc(acc_im, ar * bi);
                acc_im = sat_acc(acc_im, ai * br);
              end
            end
          end
        end else begin
          res.status = STATUS_ERR;
        end
      end
      default: res.status = STATUS_ERR;
    endcase
    res.re = acc_re[ACC_W-1:0];
    res.im = acc_im[ACC_W-1:0];
    res.lead = {1'b0, lead_a_reg} + {1'b0, lead_b_reg};
    return res;
  endfunction

  // ---------------------------------------------------------------- driving

  // Element values lean towards the corners of Q1.15.
  function automatic logic signed [IN_ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // s_tvalid still high, so the next word can follow back to back.
  task automatic push_word(input logic [1:0] act, input logic [TAP_W-1:0] tap,
                           input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                           input logic signed [IN_ELEM_W-1:0] el_re,
                           input logic signed [IN_ELEM_W-1:0] el_im);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tdata <= {5'b0, el_im, el_re, col, row, tap};
    s_tuser <= act;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_coefs.push_back(predict_coef(act, tap, row, col, el_re, el_im));
    @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding result word is back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_coefs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Raises one register write; the caller lowers cfg_wen after the last one.
  task automatic put_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    case (idx)
      REG_ROWS_A:    rows_a_reg = DIM_REG_W'(value);
      REG_INNER_DIM: inner_reg = DIM_REG_W'(value);
      REG_COLS_B:    cols_b_reg = DIM_REG_W'(value);
      REG_TAPS_A:    taps_a_reg = TAP_REG_W'(value);
      REG_TAPS_B:    taps_b_reg = TAP_REG_W'(value);
      REG_LEAD_A:    lead_a_reg = LEAD_W'(value);
      REG_LEAD_B:    lead_b_reg = LEAD_W'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Register writes only ever happen with the core drained.
  task automatic set_sizes(input int unsigned nr, input int unsigned nk, input int unsigned nc,
                           input int unsigned ta, input int unsigned tb,
                           input int unsigned la, input int unsigned lb);
    wait_idle();
    put_reg(REG_ROWS_A, nr);
    put_reg(REG_INNER_DIM, nk);
    put_reg(REG_COLS_B, nc);
    put_reg(REG_TAPS_A, ta);
    put_reg(REG_TAPS_B, tb);
    put_reg(REG_LEAD_A, la);
    put_reg(REG_LEAD_B, lb);
    cfg_wen <= 1'b0;
  endtask

  // Writes every element inside the current sizes, so any legal read is safe.
  task automatic fill_stores();
    int unsigned nr, nk, nc, ta, tb;
    nr = eff_size(rows_a_reg, MAX_DIM);
    nk = eff_size(inner_reg, MAX_DIM);
    nc = eff_size(cols_b_reg, MAX_DIM);
    ta = eff_size(taps_a_reg, MAX_TAPS);
    tb = eff_size(taps_b_reg, MAX_TAPS);
    for (int t = 0; t < ta; t++)
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nk; c++)
          push_word(ACT_LOAD_A, TAP_W'(t), IDX_W'(r), IDX_W'(c), pick_elem(), pick_elem());
    for (int t = 0; t < tb; t++)
      for (int r = 0; r < nk; r++)
        for (int c = 0; c < nc; c++)
          push_word(ACT_LOAD_B, TAP_W'(t), IDX_W'(r), IDX_W'(c), pick_elem(), pick_elem());
  endtask

  // Mostly legal loads and reads with random content, some stray addresses
  // and a few undefined actions.
  task automatic random_words(input int count);
    int unsigned nr, nk, nc, ta, tb, pick;
    nr = eff_size(rows_a_reg, MAX_DIM);
    nk = eff_size(inner_reg, MAX_DIM);
    nc = eff_size(cols_b_reg, MAX_DIM);
    ta = eff_size(taps_a_reg, MAX_TAPS);
    tb = eff_size(taps_b_reg, MAX_TAPS);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        push_word(ACT_LOAD_A, TAP_W'($urandom_range(0, ta - 1)), IDX_W'($urandom_range(0, nr - 1)),
                  IDX_W'($urandom_range(0, nk - 1)), pick_elem(), pick_elem());
      else if (pick < 50)
        push_word(ACT_LOAD_B, TAP_W'($urandom_range(0, tb - 1)), IDX_W'($urandom_range(0, nk - 1)),
                  IDX_W'($urandom_range(0, nc - 1)), pick_elem(), pick_elem());
      else if (pick < 85)
        push_word(ACT_READ, TAP_W'($urandom_range(0, ta + tb - 2)),
                  IDX_W'($urandom_range(0, nr - 1)), IDX_W'($urandom_range(0, nc - 1)),
                  pick_elem(), pick_elem());
      else if (pick < 95)
        // any address; in-range reads are still safe as the stores are full
        push_word(2'($urandom_range(0, 2)), TAP_W'($urandom), IDX_W'($urandom),
                  IDX_W'($urandom), pick_elem(), pick_elem());
      else
        push_word(ACT_NONE, TAP_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                  pick_elem(), pick_elem());
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset sizes (all 1): both loads, a read, every way out of range.
  task automatic test_reset_sizes();
    idle_pct = 20;
    push_word(ACT_LOAD_A, 5'd0, 3'd0, 3'd0, 16'sh8000, 16'sh7fff);
    push_word(ACT_LOAD_B, 5'd0, 3'd0, 3'd0, 16'sh8000, 16'sh8000);
    push_word(ACT_READ, 5'd0, 3'd0, 3'd0, 16'sh1234, 16'sh8765);
    push_word(ACT_LOAD_A, 5'd1, 3'd0, 3'd0, 16'sh0001, 16'sh0001);
    push_word(ACT_LOAD_A, 5'd0, 3'd1, 3'd0, 16'sh0002, 16'sh0002);
    push_word(ACT_LOAD_A, 5'd0, 3'd0, 3'd1, 16'sh0003, 16'sh0003);
    push_word(ACT_LOAD_B, 5'd1, 3'd0, 3'd0, 16'sh0004, 16'sh0004);
    push_word(ACT_LOAD_B, 5'd0, 3'd1, 3'd0, 16'sh0005, 16'sh0005);
    push_word(ACT_LOAD_B, 5'd0, 3'd0, 3'd1, 16'sh0006, 16'sh0006);
    push_word(ACT_READ, 5'd1, 3'd0, 3'd0, '0, '0);
    push_word(ACT_READ, 5'd0, 3'd1, 3'd0, '0, '0);
    push_word(ACT_READ, 5'd0, 3'd0, 3'd1, '0, '0);
    push_word(ACT_NONE, 5'd31, 3'd7, 3'd7, '1, '1);
    push_word(ACT_NONE, 5'd0, 3'd0, 3'd0, '0, '0);
    // opposite corners, to check the rejected loads above stored nothing
    push_word(ACT_LOAD_A, 5'd0, 3'd0, 3'd0, 16'sh7fff, 16'sh8000);
    push_word(ACT_LOAD_B, 5'd0, 3'd0, 3'd0, 16'sh7fff, 16'sh7fff);
    push_word(ACT_READ, 5'd0, 3'd0, 3'd0, '1, '1);
  endtask

  // Zero in a size register acts as 1; largest lead indices.
  task automatic test_size_clamping();
    set_sizes(0, 0, 0, 0, 0, 1023, 1023);
    push_word(ACT_READ, 5'd0, 3'd0, 3'd0, '0, '0);
    push_word(ACT_READ, 5'd1, 3'd0, 3'd0, '0, '0);
  endtask

  // Over-range sizes clamp to the maximum; every product tap of the longest
  // convolution (16 x 16 taps, inner dimension 8).
  task automatic test_longest_read();
    set_sizes(1, 15, 0, 31, 16, 0, 1023);
    idle_pct = 30;
    fill_stores();
    for (int t = 0; t < 2 * MAX_TAPS; t++)
      push_word(ACT_READ, TAP_W'(t), 3'd0, 3'd0, pick_elem(), pick_elem());
  endtask

  // Widest product with a single inner term and one tap each.
  task automatic test_wide_product();
    set_sizes(15, 1, 8, 1, 0, $urandom_range(0, 1023), 0);
    idle_pct = 10;
    fill_stores();
    random_words(60);
  endtask

  // Random sizes and leads; each phase change drains the core first.
  task automatic test_random_phases();
    for (int p = 0; p < 9; p++) begin
      set_sizes($urandom_range(0, 5), $urandom_range(1, 5), $urandom_range(1, 5),
                $urandom_range(1, 6), $urandom_range(1, 6),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      idle_pct = (p % 3) * 25;
      fill_stores();
      random_words(70);
    end
  endtask

  // Last stretch with both sides flat out.
  task automatic test_quiet_finish();
    set_sizes($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
              $urandom_range(1, 5), $urandom_range(1, 5),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
    calm = 1'b1;
    fill_stores();
    random_words(120);
  endtask

  // ---------------------------------------------------------------- processes

  // Receiver: random stall bursts while not calm.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Each result word against the oldest expected one.
  always @(posedge clk) begin : check_results
    coef_t want;
    coef_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.re = m_tdata[ACC_W-1:0];
      got.im = m_tdata[2*ACC_W-1:ACC_W];
      got.lead = m_tdata[2*ACC_W+LEAD_SUM_W-1:2*ACC_W];
      got.status = m_tuser[0];
      if (expected_coefs.size() == 0) begin
        bad_words = bad_words + 1;
        if (bad_words <= MAX_SHOWN)
          $display("unexpected result word: re %0d im %0d lead %0d status %0b",
                   got.re, got.im, got.lead, got.status);
      end else begin
        want = expected_coefs.pop_front();
        if (got.re !== want.re || got.im !== want.im || got.lead !== want.lead ||
            got.status !== want.status) begin
          bad_words = bad_words + 1;
          if (bad_words <= MAX_SHOWN)
            $display("result mismatch: expected re %0d im %0d lead %0d status %0b, got re %0d im %0d lead %0d status %0b",
                     want.re, want.im, want.lead, want.status,
                     got.re, got.im, got.lead, got.status);
        end
      end
    end
  end

  // Watchdog: nothing moving on either side for too long means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_sizes();
    test_size_clamping();
    test_longest_read();
    test_wide_product();
    test_random_phases();
    test_quiet_finish();
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (bad_words == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
